// ===== rtl/mphp_pkg.sv =====
// Shared types and constants for the mesh packet header parser.
`timescale 1ns / 1ps
`default_nettype none

package mphp_pkg;

   // Number of transport code bytes (two 16-bit codes)
   localparam logic [7:0] TRANSPORT_BYTES = 8'd4;

   // Register indexes on the csr port
   localparam logic [2:0] REG_ROUTE_MASK      = 3'd0;
   localparam logic [2:0] REG_TRANSPORT_A     = 3'd1;
   localparam logic [2:0] REG_TRANSPORT_B     = 3'd2;
   localparam logic [2:0] REG_TYPE_SHIFT      = 3'd3;
   localparam logic [2:0] REG_TYPE_MASK       = 3'd4;
   localparam logic [2:0] REG_MAX_PATH_LEN    = 3'd5;
   localparam logic [2:0] REG_MAX_PAYLOAD_LEN = 3'd6;

   typedef enum logic [2:0] {
      PH_HEADER    = 3'd0,
      PH_TRANSPORT = 3'd1,
      PH_PATHLEN   = 3'd2,
      PH_PATH      = 3'd3,
      PH_PAYLOAD   = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      FK_HEADER    = 3'd0,
      FK_TRANSPORT = 3'd1,
      FK_PATHLEN   = 3'd2,
      FK_PATH      = 3'd3,
      FK_PAYLOAD   = 3'd4
   } field_kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_TC_SHORT    = 3'd1,
      ST_NO_PATHLEN  = 3'd2,
      ST_PATH_SHORT  = 3'd3,
      ST_NO_PAYLOAD  = 3'd4,
      ST_PAYLOAD_BIG = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic [2:0] field_kind;
      logic [7:0] field_offset;
      logic [7:0] route_type;
      logic [7:0] payload_type;
      logic [7:0] path_length;
      logic [7:0] payload_length;
      logic       frame_end;
      logic [2:0] frame_status;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== rtl/mphp_req_if.sv =====
// Input byte channel: valid/ready handshake carrying one packet byte.
`timescale 1ns / 1ps
`default_nettype none

interface mphp_req_if;
   import mphp_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/mphp_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one tagged byte.
`timescale 1ns / 1ps
`default_nettype none

interface mphp_rsp_if;
   import mphp_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/mesh_packet_header_parser.sv =====
// Top level of the byte-serial mesh packet header parser.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Handshake              Word
// req_ch    in    valid/ready            data_byte, last_byte
// rsp_ch    out   valid/ready            tagged byte, held fields, status
// csr_*     in    APB write/read         seven registers of up to 8 bits at 4*index
//
// One word in, one word out. A byte is tagged in the cycle it is accepted and
// its result sits in the output register from the next cycle; 1 byte per cycle
// sustained while rsp_ch.ready stays high, set by the single output register stage.
// Synchronous active-high reset returns the parser to expecting a header.
// req_ch.ready stays high while the output register is empty or being drained,
// so a stalled result blocks only the next byte, never a drained one.

module mesh_packet_header_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   mphp_req_if.sink         req_ch,
   mphp_rsp_if.source       rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   import mphp_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [7:0] route_mask_ff;
   logic [7:0] transport_a_ff;
   logic [7:0] transport_b_ff;
   logic [2:0] type_shift_ff;
   logic [7:0] type_mask_ff;
   logic [7:0] max_path_len_ff;
   logic [7:0] max_payload_len_ff;

   logic       csr_write;
   logic [2:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         route_mask_ff      <= 8'd3;
         transport_a_ff     <= 8'd0;
         transport_b_ff     <= 8'd3;
         type_shift_ff      <= 3'd2;
         type_mask_ff       <= 8'd15;
         max_path_len_ff    <= 8'd64;
         max_payload_len_ff <= 8'd184;
      end else if (csr_write) begin
         case (csr_index)
            REG_ROUTE_MASK:      route_mask_ff      <= csr_pwdata[7:0];
            REG_TRANSPORT_A:     transport_a_ff     <= csr_pwdata[7:0];
            REG_TRANSPORT_B:     transport_b_ff     <= csr_pwdata[7:0];
            REG_TYPE_SHIFT:      type_shift_ff      <= csr_pwdata[2:0];
            REG_TYPE_MASK:       type_mask_ff       <= csr_pwdata[7:0];
            REG_MAX_PATH_LEN:    max_path_len_ff    <= csr_pwdata[7:0];
            REG_MAX_PAYLOAD_LEN: max_payload_len_ff <= csr_pwdata[7:0];
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ROUTE_MASK:      csr_prdata = {24'd0, route_mask_ff};
         REG_TRANSPORT_A:     csr_prdata = {24'd0, transport_a_ff};
         REG_TRANSPORT_B:     csr_prdata = {24'd0, transport_b_ff};
         REG_TYPE_SHIFT:      csr_prdata = {29'd0, type_shift_ff};
         REG_TYPE_MASK:       csr_prdata = {24'd0, type_mask_ff};
         REG_MAX_PATH_LEN:    csr_prdata = {24'd0, max_path_len_ff};
         REG_MAX_PAYLOAD_LEN: csr_prdata = {24'd0, max_payload_len_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake: output register with pass-through ready
   // ---------------------------------------------------------------------
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;
   logic         req_accept;

   assign req_ch.ready   = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_word_ff;

   // ---------------------------------------------------------------------
   // Frame state
   // ---------------------------------------------------------------------
   phase_type  phase_ff, phase_in;
   logic [7:0] field_count_ff, field_count_in;
   logic [7:0] held_header_ff, held_header_in;
   logic [7:0] held_path_len_ff, held_path_len_in;
   logic [7:0] payload_count_ff, payload_count_in;

   logic [7:0] in_byte;
   logic       in_last;
   logic [7:0] hdr_route;
   logic       wants_transport;
   logic [7:0] path_len_eff;
   logic [7:0] count_inc;
   logic       transport_done;
   logic       path_done;

   assign in_byte         = req_ch.payload.data_byte;
   assign in_last         = req_ch.payload.last_byte;
   assign hdr_route       = in_byte & route_mask_ff;
   assign wants_transport = (hdr_route == transport_a_ff) || (hdr_route == transport_b_ff);
   // over-limit length counts as zero: the frame goes straight to payload
   assign path_len_eff    = (in_byte > max_path_len_ff) ? 8'd0 : in_byte;
   assign count_inc       = field_count_ff + 8'd1;
   assign transport_done  = count_inc >= TRANSPORT_BYTES;
   assign path_done       = count_inc >= held_path_len_ff;

   // next phase
   always_comb begin
      case (phase_ff)
         PH_TRANSPORT: phase_in = transport_done ? PH_PATHLEN : PH_TRANSPORT;
         PH_PATHLEN:   phase_in = (path_len_eff != 8'd0) ? PH_PATH : PH_PAYLOAD;
         PH_PATH:      phase_in = path_done ? PH_PAYLOAD : PH_PATH;
         PH_PAYLOAD:   phase_in = PH_PAYLOAD;
         default:      phase_in = wants_transport ? PH_TRANSPORT : PH_PATHLEN;
      endcase
      if (in_last) begin
         phase_in = PH_HEADER;
      end
   end

   // counters, held fields and the tagged result word
   field_kind_type kind;
   status_type     status;
   logic [7:0]     offset;

   always_comb begin
      field_count_in   = field_count_ff;
      held_header_in   = held_header_ff;
      held_path_len_in = held_path_len_ff;
      payload_count_in = payload_count_ff;
      offset           = 8'd0;
      case (phase_ff)
         PH_TRANSPORT: begin
            kind           = FK_TRANSPORT;
            offset         = field_count_ff;
            field_count_in = transport_done ? 8'd0 : count_inc;
            status         = transport_done ? ST_NO_PATHLEN : ST_TC_SHORT;
         end
         PH_PATHLEN: begin
            kind             = FK_PATHLEN;
            held_path_len_in = path_len_eff;
            field_count_in   = 8'd0;
            status           = (path_len_eff != 8'd0) ? ST_PATH_SHORT : ST_NO_PAYLOAD;
         end
         PH_PATH: begin
            kind           = FK_PATH;
            offset         = field_count_ff;
            field_count_in = path_done ? 8'd0 : count_inc;
            status         = path_done ? ST_NO_PAYLOAD : ST_PATH_SHORT;
         end
         PH_PAYLOAD: begin
            kind   = FK_PAYLOAD;
            offset = payload_count_ff;
            // saturating count
            payload_count_in = (payload_count_ff == 8'hFF) ? payload_count_ff
                                                           : payload_count_ff + 8'd1;
            status = (payload_count_in > max_payload_len_ff) ? ST_PAYLOAD_BIG : ST_OK;
         end
         default: begin
            // header byte; unused phase codes also land here
            kind             = FK_HEADER;
            held_header_in   = in_byte;
            held_path_len_in = 8'd0;
            payload_count_in = 8'd0;
            field_count_in   = 8'd0;
            status           = wants_transport ? ST_TC_SHORT : ST_NO_PATHLEN;
         end
      endcase
      if (in_last) begin
         field_count_in = 8'd0;
      end

      rsp_word_in.byte_value     = in_byte;
      rsp_word_in.field_kind     = kind;
      rsp_word_in.field_offset   = offset;
      rsp_word_in.route_type     = held_header_in & route_mask_ff;
      rsp_word_in.payload_type   = (held_header_in >> type_shift_ff) & type_mask_ff;
      rsp_word_in.path_length    = held_path_len_in;
      rsp_word_in.payload_length = payload_count_in;
      rsp_word_in.frame_end      = in_last;
      rsp_word_in.frame_status   = in_last ? status : ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         field_count_ff   <= 8'd0;
         held_header_ff   <= 8'd0;
         held_path_len_ff <= 8'd0;
         payload_count_ff <= 8'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff         <= phase_in;
            field_count_ff   <= field_count_in;
            held_header_ff   <= held_header_in;
            held_path_len_ff <= held_path_len_in;
            payload_count_ff <= payload_count_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff     <= 1'b0;
         end
      end
   end

   // result word needs no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   a_last_returns_to_header: assert property (@(posedge clock) disable iff (reset)
      req_accept && in_last |=> phase_ff == PH_HEADER)
      else $error("parser not back at header after last word");

   a_header_tagged: assert property (@(posedge clock) disable iff (reset)
      req_accept && phase_ff == PH_HEADER |=>
         rsp_valid_ff && rsp_word_ff.field_kind == FK_HEADER)
      else $error("header word not tagged as header");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_word_ff.frame_end |-> rsp_word_ff.frame_status == ST_OK)
      else $error("nonzero status on a word that does not end the frame");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ch.ready)
      else $error("input stalled with an empty output register");

endmodule

`default_nettype wire
